### src/radix2_fft_engine_assert.svh
// assertion macros for the radix-2 fft engine
// needs clk and arst_n in the scope that uses them
`ifndef RADIX2_FFT_ENGINE_ASSERT_SVH
`define RADIX2_FFT_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define R2F_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("r2fft check failed");
`define R2F_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2fft check failed");
`else
`define R2F_ASSERT(label, prop)
`define R2F_ASSERT_IMP(label, ante, cons)
`endif
`endif

### src/r2fft_pkg.sv
// shared types, codes and helpers for the radix-2 fft engine
// no dependencies
package r2fft_pkg;

	localparam int SAMPLE_W = 24;
	localparam int POINT_W = 40;
	localparam int CFG_W = 32;
	localparam int CORDIC_STEPS = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// register indexes
	localparam logic [1:0] REG_LOG2_SIZE = 2'd0;
	localparam logic [1:0] REG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	typedef struct packed {
		logic cmd;
		logic signed [SAMPLE_W-1:0] sample_re;
		logic signed [SAMPLE_W-1:0] sample_im;
	} in_item_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] result_re;
		logic signed [POINT_W-1:0] result_im;
		logic last;
		logic status;
	} out_item_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [29:0] r2fft_atan(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// clamp to the signed 40-bit point range
	function automatic logic signed [POINT_W-1:0] sat40(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sh007F_FFFF_FFFF;
		lo = -48'sh0080_0000_0000;
		if (v > hi)
			return hi[POINT_W-1:0];
		else if (v < lo)
			return lo[POINT_W-1:0];
		else
			return v[POINT_W-1:0];
	endfunction

endpackage

### src/radix2_fft_engine.sv
// in-place radix-2 decimation-in-time fft with point memory and sequencer
// depends on r2fft_pkg, r2fft_cordic and radix2_fft_engine_assert.svh
//
// usage: one input channel (valid/ready) carries load and read commands, one
// output channel (valid/ready) returns one transaction per read command.
// loads write samples in order, scaled and stored at bit-reversed addresses;
// one load is taken per cycle. the load that completes 2^log2_size samples
// (log2_size 0 counts as 1; capped at log2 of MAX_POINTS) starts the transform:
// input ready stays low while it runs; its run time is set by the single memory
// port (two reads, two writes per butterfly), the four products per butterfly
// through one multiplier, and one cordic run (24 steps) per twiddle. reads
// then return points in index order via the memory read and result registers,
// with one read in the read stage at a time; the final point carries last.
// a read before the transform is done returns status 1 with zero data.
// a stalled receiver holds the result register; loads keep being taken, and
// further reads wait until the result register can take their data.
// reset: registers to defaults, counters cleared, block waits for loads;
// memory contents are not cleared.
module radix2_fft_engine import r2fft_pkg::*; #(
	parameter int MAX_POINTS = 4096,
	parameter int TWIDDLE_WIDTH = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);
	`include "radix2_fft_engine_assert.svh"

	localparam int AW = $clog2(MAX_POINTS);
	localparam int LW = $clog2(AW + 1);
	localparam int CW = AW + 1;
	localparam int IW = AW + 2;
	localparam int PW = POINT_W + TWIDDLE_WIDTH;
	localparam int TRW = PW + 1 - (TWIDDLE_WIDTH - 2);
	localparam int LPW = SAMPLE_W + CFG_W + 1;
	localparam logic signed [PW:0] RND_C = $signed((PW + 1)'(1) << (TWIDDLE_WIDTH - 3));
	localparam logic signed [LPW-1:0] LD_RND = $signed(LPW'(32768));

	localparam logic [1:0] PH_LOAD = 2'd0;
	localparam logic [1:0] PH_BUSY = 2'd1;
	localparam logic [1:0] PH_READY = 2'd2;

	localparam logic [3:0] B_TW = 4'd0;
	localparam logic [3:0] B_TWW = 4'd1;
	localparam logic [3:0] B_CHK = 4'd2;
	localparam logic [3:0] B_RDB = 4'd3;
	localparam logic [3:0] B_LDB = 4'd4;
	localparam logic [3:0] B_MUL = 4'd5;
	localparam logic [3:0] B_RND = 4'd6;
	localparam logic [3:0] B_WA = 4'd7;
	localparam logic [3:0] B_WB = 4'd8;

	// configuration registers
	logic [3:0] log2_size_q;
	logic direction_q;
	logic [CFG_W-1:0] scale_q;

	// control state
	logic [1:0] phase_q;
	logic [3:0] bstate_q;
	logic [CW-1:0] load_count_q;
	logic [CW-1:0] read_count_q;
	logic [LW-1:0] l_q;
	logic dir_q;
	logic [LW-1:0] s_q;
	logic [AW-1:0] m_q;
	logic [IW-1:0] i_q;
	logic [2:0] mstep_q;

	// load and read pipelines, result register
	logic ld_s1;
	logic [AW-1:0] ld_addr_s1;
	logic signed [LPW-1:0] ld_re_s1, ld_im_s1;
	logic rd_s1;
	logic rd_nrdy_s1;
	logic rd_last_s1;
	logic out_valid_q;
	out_item_t out_q;

	// point memory
	logic [2*POINT_W-1:0] mem [MAX_POINTS];
	logic [2*POINT_W-1:0] mem_rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [2*POINT_W-1:0] mem_wdata;

	// butterfly datapath
	logic signed [POINT_W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW:0] acc_r_q, acc_i_q;
	logic signed [TRW-1:0] tr_q, ti_q;
	logic signed [TWIDDLE_WIDTH-1:0] mul_a;
	logic signed [POINT_W-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	logic cor_start, cor_done;
	logic [31:0] cor_angle, ang_raw;
	logic signed [TWIDDLE_WIDTH-1:0] wc, ws;

	logic [LW-1:0] l_eff;
	logic [CW-1:0] n_eff;
	logic [CW-1:0] lmask;
	logic [AW-1:0] vm, rev, ld_addr;
	logic [IW-1:0] k, n_q, ipk;
	logic rd_room, in_acc, bf_we;
	logic signed [LPW-1:0] ld_rnd_re, ld_rnd_im;

	// effective transform size
	always_comb begin
		if (log2_size_q == 4'd0)
			l_eff = LW'(1);
		else if (int'(log2_size_q) > AW)
			l_eff = LW'(AW);
		else
			l_eff = LW'(log2_size_q);
		n_eff = CW'(1) << l_eff;
		lmask = n_eff - CW'(1);
	end

	// bit-reversed load address
	always_comb begin
		vm = load_count_q[AW-1:0] & lmask[AW-1:0];
		for (int j = 0; j < AW; j++)
			rev[j] = vm[AW-1-j];
		ld_addr = rev >> (LW'(AW) - l_eff);
	end

	// input handshake
	assign rd_room = !rd_s1 && (!out_valid_q || out_ready);
	assign in_ready = (phase_q != PH_BUSY) && ((in_data.cmd == CMD_LOAD) || rd_room);
	assign in_acc = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_size_q <= 4'd10;
			direction_q <= 1'b0;
			scale_q <= CFG_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOG2_SIZE: log2_size_q <= cfg_wdata[3:0];
				REG_DIRECTION: direction_q <= cfg_wdata[0];
				REG_SCALE: scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// butterfly geometry
	assign k = IW'(1) << s_q;
	assign n_q = IW'(1) << l_q;
	assign ipk = i_q + k;
	assign ang_raw = 32'(m_q) << (6'd31 - 6'(s_q));
	assign cor_angle = dir_q ? (32'd0 - ang_raw) : ang_raw;
	assign cor_start = (phase_q == PH_BUSY) && (bstate_q == B_TW);

	r2fft_cordic #(
		.TWIDDLE_WIDTH(TWIDDLE_WIDTH)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(cor_angle),
		.done(cor_done),
		.wc(wc),
		.ws(ws)
	);

	// phase, counters and butterfly sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD;
			bstate_q <= B_TW;
			load_count_q <= '0;
			read_count_q <= '0;
			l_q <= LW'(1);
			dir_q <= 1'b0;
			s_q <= '0;
			m_q <= '0;
			i_q <= '0;
			mstep_q <= 3'd0;
		end else begin
			case (phase_q)
				PH_LOAD: begin
					if (in_acc && in_data.cmd == CMD_LOAD) begin
						if (load_count_q + CW'(1) >= n_eff) begin
							phase_q <= PH_BUSY;
							bstate_q <= B_TW;
							load_count_q <= '0;
							l_q <= l_eff;
							dir_q <= direction_q;
							s_q <= '0;
							m_q <= '0;
						end else begin
							load_count_q <= load_count_q + CW'(1);
						end
					end
				end
				PH_READY: begin
					if (in_acc && in_data.cmd == CMD_READ) begin
						if (read_count_q + CW'(1) >= n_eff) begin
							phase_q <= PH_LOAD;
							read_count_q <= '0;
							load_count_q <= '0;
						end else begin
							read_count_q <= read_count_q + CW'(1);
						end
					end
				end
				PH_BUSY: begin
					case (bstate_q)
						B_TW: bstate_q <= B_TWW;
						B_TWW: begin
							if (cor_done) begin
								i_q <= IW'(m_q);
								bstate_q <= B_CHK;
							end
						end
						B_CHK: begin
							if (ipk < n_q) begin
								bstate_q <= B_RDB;
							end else if (IW'(m_q) + IW'(1) < k) begin
								m_q <= m_q + AW'(1);
								bstate_q <= B_TW;
							end else if (s_q + LW'(1) < l_q) begin
								s_q <= s_q + LW'(1);
								m_q <= '0;
								bstate_q <= B_TW;
							end else begin
								phase_q <= PH_READY;
								read_count_q <= '0;
								load_count_q <= '0;
							end
						end
						B_RDB: bstate_q <= B_LDB;
						B_LDB: begin
							mstep_q <= 3'd0;
							bstate_q <= B_MUL;
						end
						B_MUL: begin
							if (mstep_q == 3'd4)
								bstate_q <= B_RND;
							else
								mstep_q <= mstep_q + 3'd1;
						end
						B_RND: bstate_q <= B_WA;
						B_WA: bstate_q <= B_WB;
						B_WB: begin
							i_q <= i_q + (k << 1);
							bstate_q <= B_CHK;
						end
						default: bstate_q <= B_TW;
					endcase
				end
				default: phase_q <= PH_LOAD;
			endcase
		end
	end

	// multiplier operand select, one product per cycle
	always_comb begin
		case (mstep_q)
			3'd0: begin
				mul_a = wc;
				mul_b = b_re_q;
			end
			3'd1: begin
				mul_a = ws;
				mul_b = b_im_q;
			end
			3'd2: begin
				mul_a = ws;
				mul_b = b_re_q;
			end
			default: begin
				mul_a = wc;
				mul_b = b_im_q;
			end
		endcase
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	// butterfly datapath registers
	always_ff @(posedge clk) begin
		if (phase_q == PH_BUSY) begin
			case (bstate_q)
				B_RDB: begin
					a_re_q <= $signed(mem_rdata_q[2*POINT_W-1:POINT_W]);
					a_im_q <= $signed(mem_rdata_q[POINT_W-1:0]);
				end
				B_LDB: begin
					b_re_q <= $signed(mem_rdata_q[2*POINT_W-1:POINT_W]);
					b_im_q <= $signed(mem_rdata_q[POINT_W-1:0]);
				end
				B_MUL: begin
					prod_q <= mul_p;
					case (mstep_q)
						3'd1: acc_r_q <= (PW + 1)'(prod_q);
						3'd2: acc_r_q <= acc_r_q - (PW + 1)'(prod_q);
						3'd3: acc_i_q <= (PW + 1)'(prod_q);
						3'd4: acc_i_q <= acc_i_q + (PW + 1)'(prod_q);
						default: ;
					endcase
				end
				B_RND: begin
					tr_q <= TRW'((acc_r_q + RND_C) >>> (TWIDDLE_WIDTH - 2));
					ti_q <= TRW'((acc_i_q + RND_C) >>> (TWIDDLE_WIDTH - 2));
				end
				default: ;
			endcase
		end
	end

	// load scaling stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ld_s1 <= 1'b0;
		else
			ld_s1 <= in_acc && (in_data.cmd == CMD_LOAD) && (phase_q == PH_LOAD);
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.cmd == CMD_LOAD) begin
			ld_addr_s1 <= ld_addr;
			ld_re_s1 <= LPW'(in_data.sample_re) * $signed({1'b0, scale_q});
			ld_im_s1 <= LPW'(in_data.sample_im) * $signed({1'b0, scale_q});
		end
	end

	assign ld_rnd_re = (ld_re_s1 + LD_RND) >>> 16;
	assign ld_rnd_im = (ld_im_s1 + LD_RND) >>> 16;

	// memory port selection
	assign bf_we = (phase_q == PH_BUSY) && (bstate_q == B_WA || bstate_q == B_WB);
	assign mem_we = ld_s1 || bf_we;
	assign mem_raddr = (phase_q != PH_BUSY) ? read_count_q[AW-1:0] :
		(bstate_q == B_CHK) ? i_q[AW-1:0] : ipk[AW-1:0];

	always_comb begin
		if (ld_s1) begin
			mem_waddr = ld_addr_s1;
			mem_wdata = {sat40(48'(ld_rnd_re)), sat40(48'(ld_rnd_im))};
		end else if (bstate_q == B_WA) begin
			mem_waddr = i_q[AW-1:0];
			mem_wdata = {sat40(48'(a_re_q) + 48'(tr_q)), sat40(48'(a_im_q) + 48'(ti_q))};
		end else begin
			mem_waddr = ipk[AW-1:0];
			mem_wdata = {sat40(48'(a_re_q) - 48'(tr_q)), sat40(48'(a_im_q) - 48'(ti_q))};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	// read stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= in_acc && (in_data.cmd == CMD_READ);
			if (rd_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.cmd == CMD_READ) begin
			rd_nrdy_s1 <= (phase_q != PH_READY);
			rd_last_s1 <= (phase_q == PH_READY) && (read_count_q + CW'(1) >= n_eff);
		end
		if (rd_s1) begin
			if (rd_nrdy_s1) begin
				out_q.result_re <= '0;
				out_q.result_im <= '0;
			end else begin
				out_q.result_re <= $signed(mem_rdata_q[2*POINT_W-1:POINT_W]);
				out_q.result_im <= $signed(mem_rdata_q[POINT_W-1:0]);
			end
			out_q.last <= rd_last_s1;
			out_q.status <= rd_nrdy_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// checks
	`R2F_ASSERT_IMP(a_no_accept_busy, phase_q == PH_BUSY, !in_acc)
	`R2F_ASSERT_IMP(a_read_slot_free, rd_s1, !out_valid_q)
	`R2F_ASSERT_IMP(a_single_writer, ld_s1, !bf_we)
	`R2F_ASSERT_IMP(a_ready_starts_at_zero, $rose(phase_q == PH_READY), read_count_q == '0)
	`R2F_ASSERT(a_phase_legal, phase_q != 2'd3)

endmodule

### src/r2fft_cordic.sv
// iterative cordic producing one twiddle pair, one rotation step per cycle
// depends on r2fft_pkg
module r2fft_cordic import r2fft_pkg::*; #(
	parameter int TWIDDLE_WIDTH = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] angle,
	output logic done,
	output logic signed [TWIDDLE_WIDTH-1:0] wc,
	output logic signed [TWIDDLE_WIDTH-1:0] ws
);
	localparam int SH = 32 - TWIDDLE_WIDTH;
	localparam logic signed [33:0] RND = 34'sd1 <<< (SH - 1);
	localparam logic signed [33:0] LIM = 34'sd1 <<< (TWIDDLE_WIDTH - 2);

	logic busy_q;
	logic done_q;
	logic [4:0] step_q;
	logic [1:0] quad_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic signed [TWIDDLE_WIDTH-1:0] wc_q, ws_q;

	logic [1:0] quad;
	logic [31:0] red;
	logic signed [33:0] dx, dy, c, s, cr, sr;
	logic signed [32:0] at;

	// quadrant reduction of the start angle
	always_comb begin
		quad = 2'((angle + 32'h2000_0000) >> 30);
		red = angle - {quad, 30'd0};
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = $signed({3'b000, r2fft_atan(step_q)});

	// quadrant restore, rounding and clamp
	always_comb begin
		case (quad_q)
			2'd0: begin
				c = x_q;
				s = y_q;
			end
			2'd1: begin
				c = -y_q;
				s = x_q;
			end
			2'd2: begin
				c = -x_q;
				s = -y_q;
			end
			default: begin
				c = y_q;
				s = -x_q;
			end
		endcase
		cr = (c + RND) >>> SH;
		sr = (s + RND) >>> SH;
		if (cr > LIM) cr = LIM;
		if (cr < -LIM) cr = -LIM;
		if (sr > LIM) sr = LIM;
		if (sr < -LIM) sr = -LIM;
	end

	// rotation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd0;
			end else if (busy_q) begin
				if (step_q == 5'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= quad;
			x_q <= CORDIC_GAIN;
			y_q <= 34'sd0;
			z_q <= $signed({red[31], red});
		end else if (busy_q) begin
			if (step_q == 5'(CORDIC_STEPS)) begin
				wc_q <= TWIDDLE_WIDTH'(cr);
				ws_q <= TWIDDLE_WIDTH'(sr);
			end else if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign wc = wc_q;
	assign ws = ws_q;

endmodule
